// File: design/pcc_pkg.sv
// Shared widths, register map, command codes and types for the clamped PID controller.
package pcc_pkg;

  localparam int DATA_W    = 32;   // Q16.16 sample and gain width
  localparam int ERR_W     = 33;   // setpoint minus measured
  localparam int DIFF_W    = 34;   // error minus previous error
  localparam int ISUM_W    = 64;   // integral accumulator, Q32.32
  localparam int INCS_W    = 65;   // signed error times dt, Q16.48
  localparam int INC_W     = 49;   // integral increment after the floor to Q.32
  localparam int MUL_A_W   = 34;
  localparam int MUL_B_W   = 32;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int MIDHI_W   = PROD_W - MUL_A_W;
  localparam int ACC_W     = 100;  // exact P+I+D sum in Q.48
  localparam int LIMIT_W   = 15;
  localparam int FRAC_W    = 16;
  localparam int SUM_FRAC  = 48;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RATE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT = 3'd5;

  // Multiplier operand selections.
  localparam logic [2:0] MUL_NONE  = 3'd0;
  localparam logic [2:0] MUL_E_ST  = 3'd1;  // |error| * step_time
  localparam logic [2:0] MUL_E_GP  = 3'd2;  // |error| * gain_p
  localparam logic [2:0] MUL_D_GD  = 3'd3;  // |diff| * gain_d
  localparam logic [2:0] MUL_ML_SR = 3'd4;  // low part of (|diff|*gain_d) * step_rate
  localparam logic [2:0] MUL_MH_SR = 3'd5;  // high part of (|diff|*gain_d) * step_rate
  localparam logic [2:0] MUL_IL_GI = 3'd6;  // low word of |integral| * gain_i
  localparam logic [2:0] MUL_IH_GI = 3'd7;  // high word of |integral| * gain_i

  // Accumulator operations.
  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_CLR  = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;

  // Left shift applied to the product before accumulation.
  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_16 = 2'd1;
  localparam logic [1:0] SH_32 = 2'd2;
  localparam logic [1:0] SH_34 = 2'd3;

  // Source of the sign of the accumulated term.
  localparam logic [1:0] SGN_POS  = 2'd0;
  localparam logic [1:0] SGN_ERR  = 2'd1;
  localparam logic [1:0] SGN_DIFF = 2'd2;
  localparam logic [1:0] SGN_INT  = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0]  gain_p;
    logic [DATA_W-1:0]  gain_i;
    logic [DATA_W-1:0]  gain_d;
    logic [DATA_W-1:0]  step_time;
    logic [DATA_W-1:0]  step_rate;
    logic [LIMIT_W-1:0] output_limit;
  } cfg_t;

  typedef struct packed {
    logic       ld_in;     // capture a new sample
    logic       ld_diff;   // form the error difference, retire the previous error
    logic       ld_incs;   // capture the signed error*dt product
    logic       ld_dmag;   // capture |diff| and its sign
    logic       upd_isum;  // saturating integral update
    logic       ld_mid;    // keep the high part of |diff|*gain_d
    logic       ld_imag;   // capture |integral| and its sign
    logic       ld_out;    // clamp and load the result register
    logic [2:0] mul_sel;
    logic [1:0] acc_op;
    logic [1:0] acc_sh;
    logic [1:0] acc_sgn;
  } cmd_t;

endpackage

// File: design/pcc_if.sv
// Handshake channel interfaces for samples, results and configuration writes.
interface pcc_in_if;
  import pcc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] setpoint;
  logic signed [DATA_W-1:0] measured;
  modport source (output valid, output setpoint, output measured, input ready);
  modport sink   (input valid, input setpoint, input measured, output ready);
endinterface

interface pcc_out_if;
  import pcc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] drive;
  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

interface pcc_cfg_if;
  import pcc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/pcc_regs.sv
// Configuration register file with reset defaults.
module pcc_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcc_pkg::DATA_W-1:0]    cfg_data,
  output pcc_pkg::cfg_t                 cfg
);
  import pcc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_GAIN_P:       cfg_nxt.gain_p       = cfg_data;
        REG_GAIN_I:       cfg_nxt.gain_i       = cfg_data;
        REG_GAIN_D:       cfg_nxt.gain_d       = cfg_data;
        REG_STEP_TIME:    cfg_nxt.step_time    = cfg_data;
        REG_STEP_RATE:    cfg_nxt.step_rate    = cfg_data;
        REG_OUTPUT_LIMIT: cfg_nxt.output_limit = cfg_data[LIMIT_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p       <= DATA_W'(65536);
      cfg_r.gain_i       <= '0;
      cfg_r.gain_d       <= '0;
      cfg_r.step_time    <= DATA_W'(429497);
      cfg_r.step_rate    <= DATA_W'(655360000);
      cfg_r.output_limit <= LIMIT_W'(2);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: design/pcc_ctrl.sv
// Sequencer that steps the shared multiplier and accumulator through one sample.
module pcc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output pcc_pkg::cmd_t cmd
);
  import pcc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INT  = 4'd1;
  localparam logic [3:0] S_PROP = 4'd2;
  localparam logic [3:0] S_DGN  = 4'd3;
  localparam logic [3:0] S_DLO  = 4'd4;
  localparam logic [3:0] S_DHI  = 4'd5;
  localparam logic [3:0] S_ILO  = 4'd6;
  localparam logic [3:0] S_IHI  = 4'd7;
  localparam logic [3:0] S_ILST = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.ld_in = in_valid;
        if (in_valid) begin
          state_nxt = S_INT;
        end
      end
      S_INT: begin
        cmd.mul_sel = MUL_E_ST;
        cmd.ld_diff = 1'b1;
        cmd.acc_op  = ACC_CLR;
        state_nxt   = S_PROP;
      end
      S_PROP: begin
        cmd.mul_sel = MUL_E_GP;
        cmd.ld_incs = 1'b1;
        cmd.ld_dmag = 1'b1;
        state_nxt   = S_DGN;
      end
      S_DGN: begin
        cmd.mul_sel  = MUL_D_GD;
        cmd.upd_isum = 1'b1;
        cmd.acc_op   = ACC_ADD;
        cmd.acc_sh   = SH_16;
        cmd.acc_sgn  = SGN_ERR;
        state_nxt    = S_DLO;
      end
      S_DLO: begin
        cmd.mul_sel = MUL_ML_SR;
        cmd.ld_mid  = 1'b1;
        cmd.ld_imag = 1'b1;
        state_nxt   = S_DHI;
      end
      S_DHI: begin
        cmd.mul_sel = MUL_MH_SR;
        cmd.acc_op  = ACC_ADD;
        cmd.acc_sh  = SH_0;
        cmd.acc_sgn = SGN_DIFF;
        state_nxt   = S_ILO;
      end
      S_ILO: begin
        cmd.mul_sel = MUL_IL_GI;
        cmd.acc_op  = ACC_ADD;
        cmd.acc_sh  = SH_34;
        cmd.acc_sgn = SGN_DIFF;
        state_nxt   = S_IHI;
      end
      S_IHI: begin
        cmd.mul_sel = MUL_IH_GI;
        cmd.acc_op  = ACC_ADD;
        cmd.acc_sh  = SH_0;
        cmd.acc_sgn = SGN_INT;
        state_nxt   = S_ILST;
      end
      S_ILST: begin
        cmd.acc_op  = ACC_ADD;
        cmd.acc_sh  = SH_32;
        cmd.acc_sgn = SGN_INT;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        cmd.ld_out = out_free;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // An accepted sample always starts the integral step on the next cycle.
  a_accept_starts : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_INT)
    else $error("accepted sample did not start the sequence");

  // A result only appears as the sequence finishes.
  a_result_from_fin : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result raised outside the final step");

  // A finished sum waits while the result register is still occupied.
  a_fin_waits : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && out_valid_r && !out_ready |=> state_r == S_FIN && out_valid_r)
    else $error("result register overwritten before it was taken");

endmodule

// File: design/pcc_dp.sv
// Datapath: error and integral state, shared multiplier, exact accumulator and output clamp.
module pcc_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pcc_pkg::cmd_t              cmd,
  input  pcc_pkg::cfg_t              cfg,
  input  logic [pcc_pkg::DATA_W-1:0] setpoint,
  input  logic [pcc_pkg::DATA_W-1:0] measured,
  output logic [pcc_pkg::DATA_W-1:0] drive
);
  import pcc_pkg::*;

  logic [ERR_W-1:0]   err_r;
  logic [DATA_W-1:0]  emag_r;
  logic [ERR_W-1:0]   last_err_r;
  logic [DIFF_W-1:0]  diff_r;
  logic [DIFF_W-1:0]  dmag_r;
  logic               dneg_r;
  logic [INCS_W-1:0]  incs_r;
  logic [ISUM_W-1:0]  isum_r;
  logic [ISUM_W-1:0]  imag_r;
  logic               ineg_r;
  logic [MIDHI_W-1:0] midhi_r;
  logic [PROD_W-1:0]  prod_r;
  logic [ACC_W-1:0]   acc_r;
  logic [DATA_W-1:0]  drive_r;

  logic [ERR_W-1:0]   err_pos;
  logic [ERR_W-1:0]   err_neg;
  logic [DATA_W-1:0]  emag_nxt;
  logic [DIFF_W-1:0]  diff_nxt;
  logic [DIFF_W-1:0]  dmag_nxt;
  logic [INCS_W-1:0]  incs_nxt;
  logic [INC_W-1:0]   inc;
  logic [ISUM_W:0]    isum_wide;
  logic [ISUM_W-1:0]  isum_nxt;
  logic [ISUM_W-1:0]  imag_nxt;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [ACC_W-1:0]   term;
  logic               term_neg;
  logic [ACC_W-1:0]   acc_sum;
  logic [ACC_W-1:0]   lim48;
  logic [ACC_W-1:0]   lim48_neg;
  logic [DATA_W-1:0]  lim16;
  logic               over_hi;
  logic               under_lo;
  logic [DATA_W-1:0]  drive_nxt;

  assign drive = drive_r;

  // Error and its magnitude are formed side by side so no negate follows the subtract.
  always_comb begin
    err_pos  = {setpoint[DATA_W-1], setpoint} - {measured[DATA_W-1], measured};
    err_neg  = {measured[DATA_W-1], measured} - {setpoint[DATA_W-1], setpoint};
    emag_nxt = err_pos[ERR_W-1] ? err_neg[DATA_W-1:0] : err_pos[DATA_W-1:0];
  end

  always_comb begin
    diff_nxt = {err_r[ERR_W-1], err_r} - {last_err_r[ERR_W-1], last_err_r};
    dmag_nxt = diff_r[DIFF_W-1] ? (DIFF_W'(0) - diff_r) : diff_r;
    imag_nxt = isum_r[ISUM_W-1] ? (ISUM_W'(0) - isum_r) : isum_r;
  end

  // Signed error*dt, then a floor to Q.32 by arithmetic shift, then a saturating add.
  always_comb begin
    if (err_r[ERR_W-1]) begin
      incs_nxt = INCS_W'(0) - {1'b0, prod_r[2*DATA_W-1:0]};
    end else begin
      incs_nxt = {1'b0, prod_r[2*DATA_W-1:0]};
    end
    inc       = incs_r[INCS_W-1:FRAC_W];
    isum_wide = {isum_r[ISUM_W-1], isum_r} + (ISUM_W+1)'($signed(inc));
    if (isum_wide[ISUM_W] != isum_wide[ISUM_W-1]) begin
      isum_nxt = isum_wide[ISUM_W] ? {1'b1, {(ISUM_W-1){1'b0}}} : {1'b0, {(ISUM_W-1){1'b1}}};
    end else begin
      isum_nxt = isum_wide[ISUM_W-1:0];
    end
  end

  // Operand selection for the single shared multiplier.
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_E_ST: begin
        mul_a = MUL_A_W'(emag_r);
        mul_b = cfg.step_time;
      end
      MUL_E_GP: begin
        mul_a = MUL_A_W'(emag_r);
        mul_b = cfg.gain_p;
      end
      MUL_D_GD: begin
        mul_a = dmag_r;
        mul_b = cfg.gain_d;
      end
      MUL_ML_SR: begin
        mul_a = prod_r[MUL_A_W-1:0];
        mul_b = cfg.step_rate;
      end
      MUL_MH_SR: begin
        mul_a = MUL_A_W'(midhi_r);
        mul_b = cfg.step_rate;
      end
      MUL_IL_GI: begin
        mul_a = MUL_A_W'(imag_r[DATA_W-1:0]);
        mul_b = cfg.gain_i;
      end
      MUL_IH_GI: begin
        mul_a = MUL_A_W'(imag_r[ISUM_W-1:DATA_W]);
        mul_b = cfg.gain_i;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Shift the registered product into place and add it with its sign.
  always_comb begin
    case (cmd.acc_sh)
      SH_16:   term = ACC_W'({prod_r, 16'b0});
      SH_32:   term = ACC_W'({prod_r, 32'b0});
      SH_34:   term = ACC_W'({prod_r, 34'b0});
      default: term = ACC_W'(prod_r);
    endcase
    case (cmd.acc_sgn)
      SGN_ERR:  term_neg = err_r[ERR_W-1];
      SGN_DIFF: term_neg = dneg_r;
      SGN_INT:  term_neg = ineg_r;
      default:  term_neg = 1'b0;
    endcase
    acc_sum = acc_r + (term ^ {ACC_W{term_neg}}) + ACC_W'(term_neg);
  end

  // Clamp against plus or minus the limit in Q.48, otherwise floor to Q16.16.
  always_comb begin
    lim48     = ACC_W'({cfg.output_limit, {SUM_FRAC{1'b0}}});
    lim48_neg = ACC_W'(0) - lim48;
    lim16     = DATA_W'({cfg.output_limit, {FRAC_W{1'b0}}});
    over_hi   = $signed(acc_r) > $signed(lim48);
    under_lo  = $signed(acc_r) < $signed(lim48_neg);
    if (over_hi) begin
      drive_nxt = lim16;
    end else if (under_lo) begin
      drive_nxt = DATA_W'(0) - lim16;
    end else begin
      drive_nxt = acc_r[SUM_FRAC+FRAC_W-1:SUM_FRAC-FRAC_W];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (cmd.ld_in) begin
      err_r  <= err_pos;
      emag_r <= emag_nxt;
    end
    if (cmd.ld_diff) begin
      diff_r <= diff_nxt;
    end
    if (cmd.ld_incs) begin
      incs_r <= incs_nxt;
    end
    if (cmd.ld_dmag) begin
      dmag_r <= dmag_nxt;
      dneg_r <= diff_r[DIFF_W-1];
    end
    if (cmd.ld_mid) begin
      midhi_r <= prod_r[PROD_W-1:MUL_A_W];
    end
    if (cmd.ld_imag) begin
      imag_r <= imag_nxt;
      ineg_r <= isum_r[ISUM_W-1];
    end
    if (cmd.acc_op == ACC_CLR) begin
      acc_r <= '0;
    end else if (cmd.acc_op == ACC_ADD) begin
      acc_r <= acc_sum;
    end
    if (cmd.ld_out) begin
      drive_r <= drive_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      isum_r     <= '0;
      last_err_r <= '0;
    end else begin
      if (cmd.upd_isum) begin
        isum_r <= isum_nxt;
      end
      if (cmd.ld_diff) begin
        last_err_r <= err_r;
      end
    end
  end

  // Every loaded result lies within plus or minus the limit.
  a_drive_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |=>
      $signed(drive_r) <= $signed({1'b0, cfg.output_limit, {FRAC_W{1'b0}}}) &&
      $signed(drive_r) >= -$signed({1'b0, cfg.output_limit, {FRAC_W{1'b0}}}))
    else $error("drive outside the output limit");

  // A non-negative increment never lowers the integral, even at saturation.
  a_isum_up : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd_isum && !incs_r[INCS_W-1] |=> $signed(isum_r) >= $signed($past(isum_r)))
    else $error("integral fell on a non-negative increment");

  // A negative increment never raises the integral, even at saturation.
  a_isum_down : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd_isum && incs_r[INCS_W-1] |=> $signed(isum_r) <= $signed($past(isum_r)))
    else $error("integral rose on a negative increment");

endmodule

// File: design/pid_controller_clamped.sv
// Top level of the fixed-point PID controller with a clamped output.
// Each sample runs through an accept step, seven passes through the one shared 34x32
// multiplier, the last accumulate and the clamp step, and the next sample is taken only
// once the clamp step is left; a result still waiting holds the next sample in its clamp
// step. Reset (rst_n low, synchronous) clears the integral, the stored error and the
// channel state and restores the register defaults; configuration writes are always
// accepted.
module pid_controller_clamped (
  input  logic      clk,
  input  logic      rst_n,
  pcc_in_if.sink    in_ch,
  pcc_out_if.source out_ch,
  pcc_cfg_if.sink   cfg_ch
);
  import pcc_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  // The register file accepts a write transaction on every cycle. Writes are expected
  // only while no sample is in flight, so the datapath reads the registers directly.
  pcc_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_ch.valid),
    .cfg_ready (cfg_ch.ready),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .cfg       (cfg)
  );

  // The sequencer owns both handshakes. It takes a sample transaction only when idle,
  // then walks the datapath through the integral update, the proportional term, the
  // derivative term in three multiplies and the integral term in two. The result
  // register is separate, so a new sample is taken while the previous result waits;
  // only the final clamp step holds until that register has been emptied.
  pcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // The datapath keeps every term exact in Q.48 within a 100-bit accumulator, so the
  // clamp compares against the limit without any intermediate rounding. The integral
  // saturates at its 64-bit signed range and has no anti-windup.
  pcc_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cfg      (cfg),
    .setpoint (in_ch.setpoint),
    .measured (in_ch.measured),
    .drive    (out_ch.drive)
  );

endmodule

// File: test/pid_controller_clamped_tb.sv
// Self-checking testbench for the clamped fixed-point PID controller, with its own predictor.
module pid_controller_clamped_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcc_pkg::*;

  // SETTLE is twice LATENCY, which is ample settling time before a configuration write and
  // at the end of the run.
  localparam int LATENCY      = 10;
  localparam int SETTLE       = 2 * LATENCY;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 203;
  localparam int REPORT_LIMIT = 10;
  localparam int TIMEOUT_NS   = 60_000_000;

  // Register slots that decode to nothing; writes to them must leave the setting alone.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam longint ISUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint ISUM_MIN = 64'sh8000_0000_0000_0000;

  // Named register settings used by the directed table and the integral windup phase.
  localparam logic [2:0] SET_DEFAULT    = 3'd0;
  localparam logic [2:0] SET_FULL_SCALE = 3'd1;
  localparam logic [2:0] SET_ZERO_LIMIT = 3'd2;
  localparam logic [2:0] SET_ZERO_DT    = 3'd3;
  localparam logic [2:0] SET_DERIV      = 3'd4;
  localparam logic [2:0] SET_UNIT_LIMIT = 3'd5;
  localparam logic [2:0] SET_WINDUP     = 3'd6;

  typedef struct packed {
    logic [DATA_W-1:0] gp;
    logic [DATA_W-1:0] gi;
    logic [DATA_W-1:0] gd;
    logic [DATA_W-1:0] dt;
    logic [DATA_W-1:0] rate;
    logic [DATA_W-1:0] limit_word;
  } gain_set_t;

  typedef struct packed {
    logic [2:0]        set_id;
    logic [DATA_W-1:0] setpoint;
    logic [DATA_W-1:0] measured;
    logic              pinned;
    logic [DATA_W-1:0] drive;
  } dir_row_t;

  typedef struct packed {
    logic              pinned;
    logic [DATA_W-1:0] value;
  } drive_pin_t;

  localparam int DIR_ROWS = 25;

  // Directed samples. Rows with pinned set carry a drive that follows directly from the
  // setting: unit proportional gain with no integral or derivative, or a zero limit.
  dir_row_t dir_table [0:DIR_ROWS-1] = '{
    '{SET_DEFAULT,    32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{SET_DEFAULT,    32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h0002_0000},
    '{SET_DEFAULT,    32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'hFFFE_0000},
    '{SET_DEFAULT,    32'h0001_0000, 32'h0000_0000, 1'b1, 32'h0001_0000},
    '{SET_DEFAULT,    32'h0000_0000, 32'h0000_8000, 1'b1, 32'hFFFF_8000},
    '{SET_DEFAULT,    32'h0002_0000, 32'h0000_0000, 1'b1, 32'h0002_0000},
    '{SET_DEFAULT,    32'h0002_0001, 32'h0000_0000, 1'b1, 32'h0002_0000},
    '{SET_DEFAULT,    32'hFFFE_0000, 32'h0000_0000, 1'b1, 32'hFFFE_0000},
    '{SET_DEFAULT,    32'h0000_0000, 32'h0002_0001, 1'b1, 32'hFFFE_0000},
    '{SET_DEFAULT,    32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000},
    '{SET_DEFAULT,    32'h0000_0001, 32'h0000_0000, 1'b1, 32'h0000_0001},
    '{SET_DEFAULT,    32'h0000_0000, 32'h0000_0001, 1'b1, 32'hFFFF_FFFF},
    '{SET_FULL_SCALE, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0000_0000},
    '{SET_FULL_SCALE, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
    '{SET_FULL_SCALE, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{SET_FULL_SCALE, 32'h0000_0001, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{SET_ZERO_LIMIT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h0000_0000},
    '{SET_ZERO_LIMIT, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{SET_ZERO_LIMIT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h0000_0000},
    '{SET_ZERO_DT,    32'h0005_0000, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{SET_ZERO_DT,    32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
    '{SET_DERIV,      32'h0000_0100, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{SET_DERIV,      32'h0000_0000, 32'h0000_0100, 1'b0, 32'h0000_0000},
    '{SET_UNIT_LIMIT, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 32'h0001_0000},
    '{SET_UNIT_LIMIT, 32'h8000_0000, 32'h0000_0000, 1'b1, 32'hFFFF_0000}
  };

  logic clk;
  logic rst_n;

  pcc_in_if  in_ch();
  pcc_out_if out_ch();
  pcc_cfg_if cfg_ch();

  pid_controller_clamped uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor copy of the registers and of the controller state, at their reset values.
  logic [DATA_W-1:0]  k_p       = 32'd65536;
  logic [DATA_W-1:0]  k_i       = 32'd0;
  logic [DATA_W-1:0]  k_d       = 32'd0;
  logic [DATA_W-1:0]  dt_q32    = 32'd429497;
  logic [DATA_W-1:0]  rate_q16  = 32'd655360000;
  logic [LIMIT_W-1:0] lim_whole = 15'd2;
  longint             acc_integral = 0;
  longint             prev_error   = 0;

  // Expected drive values in transaction order, and the pinned values that ride along with
  // each sample from the driver to the point where the block accepts it.
  logic [DATA_W-1:0] drive_expected_q [$];
  drive_pin_t        drive_pin_q [$];

  int unsigned fail_count   = 0;
  int unsigned report_count = 0;
  int unsigned result_count = 0;

  // Traffic shaping: percentages of idle sender cycles and stalled receiver cycles.
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;

  // A long receiver hold-off is requested by toggling hold_tgl; the ready process counts it.
  logic hold_tgl  = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  // Slowly varying process used for well-formed sample sequences.
  int sp_track = 0;
  int pv_track = 0;

  logic [DATA_W-1:0] drive_want;
  drive_pin_t        pin_now;
  logic [DATA_W-1:0] drive_calc;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // One sample through the controller: error, saturating integral update, exact P+I+D sum
  // in Q.48, clamp against the whole-number limit, and the floor to Q16.16.
  function automatic logic [DATA_W-1:0] pid_next_drive(input logic [DATA_W-1:0] sp,
                                                       input logic [DATA_W-1:0] ms);
    longint             err;
    longint             diff;
    longint             inc;
    logic [63:0]        emag;
    logic [63:0]        dmag;
    logic [63:0]        imag;
    logic [63:0]        prod;
    logic [127:0]       p_term;
    logic [127:0]       i_term;
    logic [127:0]       d_term;
    logic [127:0]       total;
    logic [127:0]       lim_q48;
    logic [DATA_W-1:0]  lim_q16;
    err  = longint'($signed(sp)) - longint'($signed(ms));
    diff = err - prev_error;
    emag = (err < 0) ? -err : err;
    dmag = (diff < 0) ? -diff : diff;

    // The error*dt product is floored to Q.32, so negative values round away from zero.
    prod = emag * {32'd0, dt_q32};
    if (err < 0) begin
      inc = -longint'((prod + 64'hFFFF) >> 16);
    end else begin
      inc = longint'(prod >> 16);
    end
    if (inc > 0 && acc_integral > ISUM_MAX - inc) begin
      acc_integral = ISUM_MAX;
    end else if (inc < 0 && acc_integral < ISUM_MIN - inc) begin
      acc_integral = ISUM_MIN;
    end else begin
      acc_integral = acc_integral + inc;
    end
    imag = (acc_integral < 0) ? -acc_integral : acc_integral;

    p_term = (128'(emag) * 128'(k_p)) << 16;
    if (err < 0) begin
      p_term = -p_term;
    end
    i_term = 128'(imag) * 128'(k_i);
    if (acc_integral < 0) begin
      i_term = -i_term;
    end
    d_term = 128'(dmag) * 128'(k_d) * 128'(rate_q16);
    if (diff < 0) begin
      d_term = -d_term;
    end
    total      = p_term + i_term + d_term;
    prev_error = err;

    lim_q48 = 128'(lim_whole) << SUM_FRAC;
    lim_q16 = {1'b0, lim_whole, 16'd0};
    if ($signed(total) > $signed(lim_q48)) begin
      return lim_q16;
    end else if ($signed(total) < -$signed(lim_q48)) begin
      return -lim_q16;
    end
    return total[63:32];
  endfunction

  task automatic flag_failure(input string what);
    fail_count++;
    if (report_count < REPORT_LIMIT) begin
      report_count++;
      $display("%t ns: %s", $realtime, what);
    end
  endtask

  // Receiver: random stalls per the current mode, or a counted hold-off when requested.
  always @(posedge clk) begin
    if (hold_tgl != hold_seen) begin
      hold_seen    <= hold_tgl;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Monitor: every signal is sampled at the rising edge, before any of this edge's
  // nonblocking updates, so the view matches what the block itself sees.
  always @(posedge clk) begin
    if (rst_n) begin
      // Check a finished result transaction against the oldest expectation first, so a
      // sample accepted at the same edge cannot be mistaken for its source.
      if (out_ch.valid && out_ch.ready) begin
        result_count++;
        if (drive_expected_q.size() == 0) begin
          flag_failure($sformatf("unexpected result %0d, drive %h", result_count,
                                 out_ch.drive));
        end else begin
          drive_want = drive_expected_q.pop_front();
          if (out_ch.drive !== drive_want) begin
            flag_failure($sformatf("result %0d: drive expected %h, got %h", result_count,
                                   drive_want, out_ch.drive));
          end
        end
      end

      // An accepted sample advances the predictor; a pinned row overrides the prediction.
      if (in_ch.valid && in_ch.ready) begin
        pin_now    = drive_pin_q.pop_front();
        drive_calc = pid_next_drive(in_ch.setpoint, in_ch.measured);
        drive_expected_q.push_back(pin_now.pinned ? pin_now.value : drive_calc);
      end

      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_GAIN_P:       k_p       = cfg_ch.data;
          REG_GAIN_I:       k_i       = cfg_ch.data;
          REG_GAIN_D:       k_d       = cfg_ch.data;
          REG_STEP_TIME:    dt_q32    = cfg_ch.data;
          REG_STEP_RATE:    rate_q16  = cfg_ch.data;
          REG_OUTPUT_LIMIT: lim_whole = cfg_ch.data[LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Offers one sample transaction, after a random idle gap, and returns at the edge where it
  // is accepted. Valid stays high into the next call when no gap follows.
  task automatic send_sample(input logic [DATA_W-1:0] sp, input logic [DATA_W-1:0] ms,
                             input logic pinned, input logic [DATA_W-1:0] pin_value);
    int gap;
    gap = 0;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      gap++;
    end
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    drive_pin_q.push_back('{pinned, pin_value});
    in_ch.valid    <= 1'b1;
    in_ch.setpoint <= sp;
    in_ch.measured <= ms;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stops offering samples and waits until every result is back and the block has settled,
  // so that registers are only ever written while the block is idle. The first edge lets
  // the monitor record a sample accepted at the edge where this task was entered.
  task automatic drain_pipeline();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (drive_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes all six registers back to back, then one write to a slot that decodes to nothing.
  task automatic apply_setting(input gain_set_t s);
    logic [DATA_W-1:0]    word [0:6];
    logic [CFG_IDX_W-1:0] slot [0:6];
    slot[0] = REG_GAIN_P;       word[0] = s.gp;
    slot[1] = REG_GAIN_I;       word[1] = s.gi;
    slot[2] = REG_GAIN_D;       word[2] = s.gd;
    slot[3] = REG_STEP_TIME;    word[3] = s.dt;
    slot[4] = REG_STEP_RATE;    word[4] = s.rate;
    slot[5] = REG_OUTPUT_LIMIT; word[5] = s.limit_word;
    slot[6] = $urandom_range(1) ? REG_SPARE_A : REG_SPARE_B;
    word[6] = $urandom;
    for (int k = 0; k < 7; k++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= slot[k];
      cfg_ch.data  <= word[k];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic gain_set_t named_setting(input logic [2:0] id);
    gain_set_t s;
    case (id)
      // Every register at its top value; the limit word masks down to 32767.
      SET_FULL_SCALE: s = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF};
      // Large gains but a limit word whose low bits are zero, which forces the drive to zero.
      SET_ZERO_LIMIT: s = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, 32'hFFFF_8000};
      // Zero dt freezes the integral, which then shows alone through unit integral gain.
      SET_ZERO_DT:    s = '{32'd0, 32'd65536, 32'd0, 32'd0, 32'd0, 32'd32766};
      SET_DERIV:      s = '{32'd0, 32'd0, 32'd65536, 32'd429497, 32'd655360000, 32'd32766};
      // An odd limit below the usual range.
      SET_UNIT_LIMIT: s = '{32'd65536, 32'd0, 32'd0, 32'd429497, 32'd655360000, 32'd1};
      // Maximum dt and the smallest integral gain make the integral visible at the output.
      SET_WINDUP:     s = '{32'd0, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd32767};
      default:        s = '{32'd65536, 32'd0, 32'd0, 32'd429497, 32'd655360000, 32'd2};
    endcase
    return s;
  endfunction

  function automatic logic [DATA_W-1:0] pick_gain();
    case ($urandom_range(7))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom;
      default: return $urandom_range(0, 32'h0004_0000);
    endcase
  endfunction

  function automatic gain_set_t random_setting();
    gain_set_t s;
    s.gp   = pick_gain();
    s.gi   = pick_gain();
    s.gd   = pick_gain();
    s.rate = pick_gain();
    case ($urandom_range(5))
      0:       s.dt = 32'd0;
      1:       s.dt = 32'hFFFF_FFFF;
      2, 3:    s.dt = $urandom;
      default: s.dt = $urandom_range(0, 32'h0100_0000);
    endcase
    case ($urandom_range(9))
      0:       s.limit_word = 32'd0;
      1:       s.limit_word = 32'd1;
      2:       s.limit_word = 32'd2;
      3:       s.limit_word = 32'd32766;
      4:       s.limit_word = 32'd32767;
      default: s.limit_word = $urandom;
    endcase
    return s;
  endfunction

  // Most samples follow a process value that tracks a setpoint, which keeps errors small
  // enough for unclamped outputs; the rest are raw noise and full-scale corners.
  task automatic next_sample(output logic [DATA_W-1:0] sp, output logic [DATA_W-1:0] ms);
    int noise;
    logic [DATA_W-1:0] corner [0:3];
    corner[0] = 32'h7FFF_FFFF;
    corner[1] = 32'h8000_0000;
    corner[2] = 32'h0000_0000;
    corner[3] = 32'hFFFF_FFFF;
    case ($urandom_range(9))
      0, 1, 2: begin
        sp = $urandom;
        ms = $urandom;
      end
      3: begin
        sp = corner[$urandom_range(3)];
        ms = corner[$urandom_range(3)];
      end
      default: begin
        if ($urandom_range(19) == 0) begin
          sp_track = $signed($urandom) >>> $urandom_range(0, 30);
        end
        noise    = $signed($urandom) >>> $urandom_range(12, 31);
        pv_track = pv_track + ((sp_track - pv_track) >>> 2) + noise;
        sp = sp_track;
        ms = pv_track;
      end
    endcase
  endtask

  initial begin
    logic [2:0]        cur_set;
    logic [DATA_W-1:0] sp;
    logic [DATA_W-1:0] ms;

    in_ch.valid    <= 1'b0;
    in_ch.setpoint <= '0;
    in_ch.measured <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= '0;
    cfg_ch.data    <= '0;
    rst_n          <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. The first rows run on the reset values of the registers, so those
    // are checked without any write; later rows switch settings only between drains.
    cur_set = SET_DEFAULT;
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_table[r].set_id != cur_set) begin
        drain_pipeline();
        cur_set = dir_table[r].set_id;
        apply_setting(named_setting(cur_set));
      end
      send_sample(dir_table[r].setpoint, dir_table[r].measured, dir_table[r].pinned,
                  dir_table[r].drive);
    end

    // Random part: a fresh setting per phase, cycling through the traffic modes.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_pipeline();
      apply_setting(random_setting());
      case (ph % 4)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 70; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 70; end
        default: begin tx_idle_pct = 36; rx_stall_pct = 36; end
      endcase
      // Early on, the receiver holds off for a long stretch while samples keep coming, so
      // the block fills up and has to stall its input.
      if (ph == 0) begin
        hold_tgl <= ~hold_tgl;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        next_sample(sp, ms);
        send_sample(sp, ms, 1'b0, '0);
      end
    end

    // Integral windup: full-scale positive error at maximum dt builds the integral up fast,
    // then negative error pulls it back down and positive error drives it up again.
    drain_pipeline();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    apply_setting(named_setting(SET_WINDUP));
    repeat (8) send_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0);
    repeat (12) send_sample(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0);
    repeat (4) send_sample(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0);

    // Let every result come back, then watch a while longer for stray results.
    drain_pipeline();
    if (fail_count == 0 && drive_expected_q.size() == 0) begin
      $display("** pid_controller_clamped: PASSED **");
    end else begin
      $display("** pid_controller_clamped: FAILED **");
    end
    $finish;
  end

  // Watchdog: a stuck handshake ends the run as a failure.
  initial begin
    #TIMEOUT_NS;
    $display("** pid_controller_clamped: FAILED **");
    $finish;
  end

endmodule
